// File: hdl/scalenx_pixel_art_upscaler_unit_defines.svh
// assertion helpers
`ifndef SCALENX_PIXEL_ART_UPSCALER_UNIT_DEFINES_SVH
`define SCALENX_PIXEL_ART_UPSCALER_UNIT_DEFINES_SVH
`define SNX_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SNX_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`endif

// File: hdl/snx_pkg.sv
package snx_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int DIM_BITS       = 11;
  localparam int COORD_BITS     = 12;
  localparam int PIX_W          = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE  = 2'd2;

  // one centre job handed from front to back
  typedef struct packed {
    logic [13:0] x;
    logic [13:0] y;
    logic [13:0] x0;
    logic [13:0] x2;
    logic [1:0]  b0;
    logic [1:0]  b1;
    logic [1:0]  b2;
    logic        s3;
    logic        last;
    logic        fdone;
  } job_t;
endpackage

// File: hdl/snx_front.sv
module snx_front #(
  parameter int MAX_WIDTH  = snx_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = snx_pkg::MAX_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [snx_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_fire,
  input  logic busy,
  output logic in_ready,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  output logic [1:0] wr_bank,
  output logic job_valid,
  input  logic job_ready,
  output snx_pkg::job_t job
);
  import snx_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [DIM_BITS-1:0] image_width, image_height;
  logic [1:0] scale_factor;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [1:0] bank, bank_m1;
  logic [13:0] w, h;
  logic [2:0] njobs, jidx;
  logic pending;
  logic [13:0] pc, pr;
  logic [1:0] pb, pbm1;
  logic [13:0] wm1, hm1;

  always_comb begin
    w = (image_width == '0) ? 14'd1 :
        ({3'd0, image_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'd0, image_width};
    h = (image_height == '0) ? 14'd1 :
        ({3'd0, image_height} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {3'd0, image_height};
    wm1 = w - 14'd1;
    hm1 = h - 14'd1;
  end

  assign in_ready = !pending;
  assign wr_col = col;
  assign wr_bank = bank;

  // job list for pending input: cols {c-1 if c>=1, c if last}, rows likewise
  logic hasxa, hasxb, hasya, hasyb;
  logic [1:0] nx, ny;
  logic xsel, ysel;
  logic [13:0] jx, jy;
  logic [1:0] jb;
  always_comb begin
    hasxa = pc != 14'd0;
    hasxb = pc == wm1;
    hasya = pr != 14'd0;
    hasyb = pr == hm1;
    nx = 2'(hasxa) + 2'(hasxb);
    ny = 2'(hasya) + 2'(hasyb);
    xsel = (nx == 2'd2) ? jidx[0] : !hasxa;
    if (ny == 2'd2) ysel = (nx == 2'd2) ? jidx[1] : jidx[0];
    else ysel = !hasya;
    jx = xsel ? pc : pc - 14'd1;
    jy = ysel ? pr : pr - 14'd1;
    jb = ysel ? pb : pbm1;
    job.x = jx;
    job.y = jy;
    job.x0 = (jx == 14'd0) ? 14'd0 : jx - 14'd1;
    job.x2 = (jx == wm1) ? wm1 : jx + 14'd1;
    job.b1 = jb;
    job.b0 = (jy == 14'd0) ? jb : ((jb == 2'd0) ? 2'd2 : jb - 2'd1);
    job.b2 = (jy == hm1) ? jb : ((jb == 2'd2) ? 2'd0 : jb + 2'd1);
    job.s3 = scale_factor == 2'd3;
    job.last = (jidx + 3'd1) == njobs;
    job.fdone = job.last && hasxb && hasyb;
  end
  assign job_valid = pending && njobs != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'(1024);
      image_height <= 11'(1024);
      scale_factor <= 2'd2;
      col <= '0;
      row <= '0;
      bank <= 2'd0;
      bank_m1 <= 2'd2;
      pending <= 1'b0;
      jidx <= '0;
      njobs <= '0;
    end else begin
      if (cfg_valid && !busy) begin
        unique case (cfg_index)
          REG_WIDTH: image_width <= cfg_data[DIM_BITS-1:0];
          REG_HEIGHT: image_height <= cfg_data[DIM_BITS-1:0];
          REG_SCALE: scale_factor <= cfg_data[1:0];
          default: ;
        endcase
        if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT || cfg_index == REG_SCALE) begin
          col <= '0;
          row <= '0;
          bank <= 2'd0;
          bank_m1 <= 2'd2;
        end
      end
      if (in_fire) begin
        pending <= 1'b1;
        jidx <= '0;
        pc <= 14'(col);
        pr <= 14'(row);
        pb <= bank;
        pbm1 <= bank_m1;
        njobs <= 3'(((col != '0) ? 2'd1 : 2'd0) + ((14'(col) == wm1) ? 2'd1 : 2'd0)) *
                 3'(((row != '0) ? 2'd1 : 2'd0) + ((14'(row) == hm1) ? 2'd1 : 2'd0));
        if (14'(col) == wm1) begin
          col <= '0;
          if (14'(row) == hm1) begin
            row <= '0;
            bank <= 2'd0;
            bank_m1 <= 2'd2;
          end else begin
            row <= row + RW'(1);
            bank_m1 <= bank;
            bank <= (bank == 2'd2) ? 2'd0 : bank + 2'd1;
          end
        end else begin
          col <= col + CW'(1);
        end
      end else if (pending) begin
        if (njobs == 3'd0) pending <= 1'b0;
        else if (job_ready) begin
          jidx <= jidx + 3'd1;
          if (job.last) pending <= 1'b0;
        end
      end
    end
  end
endmodule

// File: hdl/snx_queue.sv
module snx_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  snx_pkg::job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output snx_pkg::job_t out_job
);
  import snx_pkg::*;
  job_t mem [0:1];
  logic [1:0] cnt;
  logic rp, wp;
  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_job = mem[rp];
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_job;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rp <= 1'b0;
      wp <= 1'b0;
    end else begin
      if (in_valid && in_ready) wp <= !wp;
      if (out_valid && out_ready) rp <= !rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

// File: hdl/snx_back.sv
module snx_back #(
  parameter int MAX_WIDTH  = snx_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = snx_pkg::PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [1:0] wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [PIXEL_BITS-1:0] wr_data,
  input  logic job_valid,
  output logic job_ready,
  input  snx_pkg::job_t job,
  output logic busy,
  output logic rd_active,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [snx_pkg::PIX_W-1:0] pix,
  output logic [snx_pkg::COORD_BITS-1:0] ox,
  output logic [snx_pkg::COORD_BITS-1:0] oy,
  output logic last,
  output logic fdone
);
  import snx_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(3 * MAX_WIDTH);

  logic [PIXEL_BITS-1:0] mem [0:3*MAX_WIDTH-1];
  logic [PIXEL_BITS-1:0] rdata;
  logic [PIXEL_BITS-1:0] nb [0:8];
  logic [AW-1:0] waddr, raddr;
  logic [3:0] rd_step, cap_idx;
  logic rd_busy, cap_en;
  logic [3:0] oidx, ocnt;
  logic oact;
  job_t cur;
  logic [PIXEL_BITS-1:0] res [0:8];
  logic [1:0] oi, oj;

  function automatic logic [AW-1:0] addr(input logic [1:0] b, input logic [13:0] c);
    addr = AW'(b) * AW'(MAX_WIDTH) + AW'(c[CW-1:0]);
  endfunction

  assign waddr = AW'(wr_bank) * AW'(MAX_WIDTH) + AW'(wr_col);
  always_comb begin
    logic [1:0] b;
    logic [13:0] c;
    b = (rd_step < 4'd3) ? cur.b0 : (rd_step < 4'd6) ? cur.b1 : cur.b2;
    case (rd_step)
      4'd0, 4'd3, 4'd6: c = cur.x0;
      4'd1, 4'd4, 4'd7: c = cur.x;
      default: c = cur.x2;
    endcase
    raddr = addr(b, c);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wr_data;
    rdata <= mem[raddr];
    if (cap_en) nb[cap_idx] <= rdata;
  end

  // gather 9 reads, then emit; next job starts only after outputs drained
  assign job_ready = !rd_busy && !cap_en && !oact && !(m_tvalid && !m_tready);
  assign busy = rd_busy || cap_en || oact || m_tvalid || job_valid;
  assign rd_active = rd_busy;

  always_comb begin
    logic [PIXEL_BITS-1:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
    logic db, dh, fb, fh, ea, eg, ec, ei;
    pa = nb[0]; pb = nb[1]; pc = nb[2]; pd = nb[3]; pe = nb[4];
    pf = nb[5]; pg = nb[6]; ph = nb[7]; pi = nb[8];
    db = pd == pb; dh = pd == ph; fb = pf == pb; fh = pf == ph;
    ea = pe == pa; eg = pe == pg; ec = pe == pc; ei = pe == pi;
    for (int k = 0; k < 9; k++) res[k] = pe;
    if (pb != ph && pd != pf) begin
      if (cur.s3) begin
        if (db) res[0] = pd;
        if ((db && !ec) || (fb && !ea)) res[1] = pb;
        if (fb) res[2] = pf;
        if ((db && !eg) || (dh && !ea)) res[3] = pd;
        if ((fb && !ei) || (fh && !ec)) res[5] = pf;
        if (dh) res[6] = pd;
        if ((dh && !ei) || (fh && !eg)) res[7] = ph;
        if (fh) res[8] = pf;
      end else begin
        if (db) res[0] = pd;
        if (fb) res[1] = pf;
        if (dh) res[2] = pd;
        if (fh) res[3] = pf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy <= 1'b0;
      rd_step <= '0;
      cap_en <= 1'b0;
      cap_idx <= '0;
      oact <= 1'b0;
      m_tvalid <= 1'b0;
      oidx <= '0;
      oi <= '0;
      oj <= '0;
    end else begin
      cap_en <= rd_busy;
      cap_idx <= rd_step;
      if (job_valid && job_ready) begin
        cur <= job;
        rd_busy <= 1'b1;
        rd_step <= '0;
      end else if (rd_busy) begin
        if (rd_step == 4'd8) rd_busy <= 1'b0;
        rd_step <= rd_step + 4'd1;
      end
      if (cap_en && cap_idx == 4'd8) begin
        oact <= 1'b1;
        oidx <= '0;
        oi <= '0;
        oj <= '0;
        ocnt <= cur.s3 ? 4'd9 : 4'd4;
      end
      if (oact && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        pix <= PIX_W'(res[oidx]);
        ox <= COORD_BITS'(cur.x * (cur.s3 ? 14'd3 : 14'd2) + 14'(oi));
        oy <= COORD_BITS'(cur.y * (cur.s3 ? 14'd3 : 14'd2) + 14'(oj));
        last <= cur.last && (oidx + 4'd1 == ocnt);
        fdone <= cur.fdone && (oidx + 4'd1 == ocnt);
        oidx <= oidx + 4'd1;
        if (oidx + 4'd1 == ocnt) oact <= 1'b0;
        if (oi == (cur.s3 ? 2'd2 : 2'd1)) begin
          oi <= '0;
          oj <= oj + 2'd1;
        end else begin
          oi <= oi + 2'd1;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`include "scalenx_pixel_art_upscaler_unit_defines.svh"
  `SNX_ASSERT_IMP(a_no_accept_while_reading, rd_busy, !job_ready, "job taken mid gather")
  `SNX_ASSERT_IMP(a_gather_end, cap_en && cap_idx == 4'd8, !oact, "emit overlap")
  `SNX_ASSERT(a_idx_range, oidx <= 4'd9, "output index out of range")
endmodule

// File: hdl/scalenx_pixel_art_upscaler_unit.sv
// channel  direction  payload
// s_axis   in         tdata: src_pixel
// m_axis   out        tdata: out_pixel, out_x, out_y; tuser: run_last, frame_done
// cfg      in         cfg_index, cfg_data
// each centre goes from the queue through 9 line store reads (one port) to its
// first output pixel, then 4 or 9 pixels, one per cycle unless m_axis stalls
// an input is taken once the previous input's centres have all been read
// rst is synchronous and clears counters and registers; line store is not cleared
// m_axis stalls back up through the back end and the job queue
module scalenx_pixel_art_upscaler_unit #(
  parameter int MAX_WIDTH  = snx_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = snx_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = snx_pkg::PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata, // src_pixel
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [55:0] m_axis_tdata, // out_pixel, out_x, out_y
  output logic [1:0] m_axis_tuser, // run_last, frame_done
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [snx_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import snx_pkg::*;
  logic in_fire, busy, jv, jr, qv, qr, in_ready, brd;
  logic [$clog2(MAX_WIDTH)-1:0] wr_col;
  logic [1:0] wr_bank;
  job_t fj, qj;
  logic [PIX_W-1:0] pix;
  logic [COORD_BITS-1:0] ox, oy;
  logic last, fdone, bbusy;

  assign s_axis_tready = in_ready && !qv && !brd;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = !busy;
  assign busy = bbusy || jv || qv || !in_ready || in_fire;

  snx_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .in_fire, .busy,
    .in_ready, .wr_col, .wr_bank, .job_valid(jv), .job_ready(jr), .job(fj));

  snx_queue u_queue (.clk, .rst, .in_valid(jv), .in_ready(jr), .in_job(fj),
    .out_valid(qv), .out_ready(qr), .out_job(qj));

  snx_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst, .wr_en(in_fire), .wr_bank, .wr_col,
    .wr_data(s_axis_tdata[PIXEL_BITS-1:0]), .job_valid(qv), .job_ready(qr),
    .job(qj), .busy(bbusy), .rd_active(brd), .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready), .pix, .ox, .oy, .last, .fdone);

  assign m_axis_tdata = {oy, ox, pix};
  assign m_axis_tuser = {fdone, last};
endmodule

// File: tb/sv/scalenx_pixel_art_upscaler_unit_tb.sv
module scalenx_pixel_art_upscaler_unit_tb;
  import snx_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int LINE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [31:0] pix;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
    logic        done;
  } out_pix_t;

  typedef struct {
    bit                      is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [31:0]             data;
    bit                      chk;
    logic [31:0]             exp_pix;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  scalenx_pixel_art_upscaler_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] line_mem [3*LINE_DEPTH];
  int unsigned col_pos, row_pos;
  logic [10:0] width_reg, height_reg;
  logic [1:0]  scale_reg;
  out_pix_t    exp_pixels[$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int items = 0;
  logic [31:0] palette[3];

  function automatic logic [31:0] line_at(int unsigned r, int unsigned c);
    return line_mem[(r % 3) * LINE_DEPTH + (c % LINE_DEPTH)];
  endfunction

  task automatic scale_centre(int unsigned x, int unsigned y, int unsigned w,
                              int unsigned h, int unsigned s);
    int unsigned x0, x2, y0, y2;
    logic [31:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
    logic [31:0] res[9];
    bit db, dh, fb, fh, ea, eg, ec, ei;
    out_pix_t o;
    x0 = (x > 0) ? x - 1 : 0;
    x2 = (x + 1 < w) ? x + 1 : w - 1;
    y0 = (y > 0) ? y - 1 : 0;
    y2 = (y + 1 < h) ? y + 1 : h - 1;
    pa = line_at(y0, x0); pb = line_at(y0, x); pc = line_at(y0, x2);
    pd = line_at(y, x0);  pe = line_at(y, x);  pf = line_at(y, x2);
    pg = line_at(y2, x0); ph = line_at(y2, x); pi = line_at(y2, x2);
    for (int k = 0; k < 9; k++) res[k] = pe;
    if (pb != ph && pd != pf) begin
      if (s == 3) begin
        db = (pd == pb); dh = (pd == ph); fb = (pf == pb); fh = (pf == ph);
        ea = (pe == pa); eg = (pe == pg); ec = (pe == pc); ei = (pe == pi);
        if (db) res[0] = pd;
        if ((db && !ec) || (fb && !ea)) res[1] = pb;
        if (fb) res[2] = pf;
        if ((db && !eg) || (dh && !ea)) res[3] = pd;
        if ((fb && !ei) || (fh && !ec)) res[5] = pf;
        if (dh) res[6] = pd;
        if ((dh && !ei) || (fh && !eg)) res[7] = ph;
        if (fh) res[8] = pf;
      end else begin
        if (pb == pd) res[0] = pd;
        if (pb == pf) res[1] = pf;
        if (ph == pd) res[2] = pd;
        if (ph == pf) res[3] = pf;
      end
    end
    for (int j = 0; j < s; j++) begin
      for (int i = 0; i < s; i++) begin
        o.pix = res[j * s + i];
        o.x = 12'(x * s + i);
        o.y = 12'(y * s + j);
        o.last = 1'b0;
        o.done = 1'b0;
        exp_pixels.push_back(o);
      end
    end
  endtask

  task automatic upscale_pixel(logic [31:0] p);
    int unsigned w, h, s, c, r, n0;
    int unsigned ys[$], xs[$];
    w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    s = (scale_reg == 2'd3) ? 3 : 2;
    c = col_pos;
    r = row_pos;
    n0 = exp_pixels.size();
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    line_mem[(r % 3) * LINE_DEPTH + c] = p;
    if (r >= 1) ys.push_back(r - 1);
    if (r == h - 1) ys.push_back(r);
    if (c >= 1) xs.push_back(c - 1);
    if (c == w - 1) xs.push_back(c);
    foreach (ys[a]) foreach (xs[b]) scale_centre(xs[b], ys[a], w, h, s);
    if (exp_pixels.size() > n0) begin
      exp_pixels[exp_pixels.size()-1].last = 1'b1;
      if (c == w - 1 && r == h - 1) exp_pixels[exp_pixels.size()-1].done = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // caller stands at a falling edge
  task automatic send_pixel(logic [31:0] p);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    do @(posedge clk); while (!s_axis_tready);
    upscale_pixel(p);
    items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH: width_reg = d[10:0];
      REG_HEIGHT: height_reg = d[10:0];
      REG_SCALE: scale_reg = d[1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned s);
    wait_idle();
    write_reg(REG_WIDTH, ($urandom & ~32'h7ff) | w);
    write_reg(REG_HEIGHT, ($urandom & ~32'h7ff) | h);
    write_reg(REG_SCALE, ($urandom & ~32'h3) | s);
  endtask

  function automatic logic [31:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(9);
    return (r < 8) ? palette[r % 3] : $urandom;
  endfunction

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_pix_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction data=%h user=%b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        e = exp_pixels.pop_front();
        if (m_axis_tdata[31:0] !== e.pix) begin
          errors++;
          $display("%0t: out_pixel exp %h got %h", $time, e.pix, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[43:32] !== e.x) begin
          errors++;
          $display("%0t: out_x exp %0d got %0d", $time, e.x, m_axis_tdata[43:32]);
        end
        if (m_axis_tdata[55:44] !== e.y) begin
          errors++;
          $display("%0t: out_y exp %0d got %0d", $time, e.y, m_axis_tdata[55:44]);
        end
        if (m_axis_tuser[0] !== e.last) begin
          errors++;
          $display("%0t: run_last exp %b got %b", $time, e.last, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== e.done) begin
          errors++;
          $display("%0t: frame_done exp %b got %b", $time, e.done, m_axis_tuser[1]);
        end
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{0, REG_WIDTH, 32'h0000_0000, 0, 32'h0},
    '{0, REG_WIDTH, 32'hffff_ffff, 0, 32'h0},
    '{1, REG_UNUSED, 32'h0000_0005, 0, 32'h0},
    '{1, REG_WIDTH, 32'd1, 0, 32'h0},
    '{1, REG_HEIGHT, 32'd1, 0, 32'h0},
    '{1, REG_SCALE, 32'd2, 0, 32'h0},
    '{0, REG_WIDTH, 32'h0000_0000, 1, 32'h0000_0000},
    '{0, REG_WIDTH, 32'hffff_ffff, 1, 32'hffff_ffff},
    '{1, REG_SCALE, 32'd3, 0, 32'h0},
    '{0, REG_WIDTH, 32'ha5a5_a5a5, 1, 32'ha5a5_a5a5},
    '{1, REG_WIDTH, 32'd0, 0, 32'h0},
    '{1, REG_HEIGHT, 32'd0, 0, 32'h0},
    '{1, REG_SCALE, 32'd0, 0, 32'h0},
    '{0, REG_WIDTH, 32'h5a5a_5a5a, 1, 32'h5a5a_5a5a},
    '{1, REG_WIDTH, 32'd3, 0, 32'h0},
    '{1, REG_HEIGHT, 32'd3, 0, 32'h0},
    '{1, REG_SCALE, 32'd1, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h0000_0000, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0},
    '{0, REG_WIDTH, 32'h3333_3333, 0, 32'h0},
    '{0, REG_WIDTH, 32'h3333_3333, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0},
    '{1, REG_SCALE, 32'd3, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0},
    '{0, REG_WIDTH, 32'h1111_1111, 0, 32'h0},
    '{0, REG_WIDTH, 32'h0000_0000, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0},
    '{0, REG_WIDTH, 32'h3333_3333, 0, 32'h0},
    '{0, REG_WIDTH, 32'h3333_3333, 0, 32'h0},
    '{0, REG_WIDTH, 32'h2222_2222, 0, 32'h0}
  };

  initial begin
    int unsigned n0, w, h, s, npix;
    int mode;
    col_pos = 0;
    row_pos = 0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    scale_reg = 2'd2;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        n0 = exp_pixels.size();
        send_pixel(dir_rows[k].data);
        if (dir_rows[k].chk) begin
          for (int q = n0; q < exp_pixels.size(); q++) begin
            if (exp_pixels[q].pix !== dir_rows[k].exp_pix) begin
              errors++;
              $display("%0t: uniform pixel exp %h predicted %h", $time,
                       dir_rows[k].exp_pix, exp_pixels[q].pix);
            end
          end
        end
      end
    end

    // width and height extremes, the widest saturated and in 3x
    palette = '{32'h0, 32'hffff_ffff, $urandom};
    set_frame(1024, 1, 2);
    repeat (40) send_pixel(pick_pixel());
    set_frame(2047, 1, 3);
    repeat (40) send_pixel(pick_pixel());
    set_frame(1, 2000, 3);
    repeat (40) send_pixel(pick_pixel());
    set_frame(2, 1024, 2);
    repeat (30) send_pixel(pick_pixel());

    // random frames across idling modes
    mode = 0;
    while (items < 450) begin
      case (mode % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 55; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 55; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      mode++;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      s = $urandom_range(0, 3);
      palette = '{$urandom, $urandom, $urandom};
      if ($urandom_range(3) == 0) palette[0] = 32'h0;
      if ($urandom_range(3) == 0) palette[1] = 32'hffff_ffff;
      set_frame(w, h, s);
      npix = w * h * $urandom_range(1, 2);
      if ($urandom_range(5) == 0) npix = $urandom_range(1, w * h);
      repeat (npix) send_pixel(pick_pixel());
    end

    s_axis_tvalid <= 1'b0;
    while (exp_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
